[hdl/cgg_pkg.sv]
//------------------------------------------------------------------------------
// cgg_pkg
// Shared item types for the color gradient generator.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cgg_pkg;

    // Width of one color channel.
    localparam int unsigned CHAN_W = 8;

    // One request item.
    typedef struct packed {
        logic [7:0] base_red;
        logic [7:0] base_green;
        logic [7:0] base_blue;
        logic [7:0] target_red;
        logic [7:0] target_green;
        logic [7:0] target_blue;
        logic [6:0] color_count;
        logic       mirror;
        logic       use_offset;
        logic [7:0] offset;
    } t_in_item;

    // One gradient entry item.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [5:0] position;
        logic       last;
    } t_out_item;

endpackage

`default_nettype wire

[hdl/cgg_lane.sv]
//------------------------------------------------------------------------------
// cgg_lane
// One color channel: serial step divide, then entry value for a ramp index.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cgg_lane
    import cgg_pkg::*;
#(
    parameter int unsigned LEN_W = 7
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [CHAN_W-1:0] i_base,
    input  wire logic [CHAN_W-1:0] i_target,
    input  wire logic [LEN_W-1:0]  i_len,
    input  wire logic [LEN_W-1:0]  i_idx,
    output logic                   o_done,
    output logic [CHAN_W-1:0]      o_color
);

    localparam int unsigned CNT_W = $clog2(CHAN_W);

    logic              r_busy;
    logic [CNT_W-1:0]  r_cnt;
    logic [CHAN_W-1:0] r_base;
    logic [CHAN_W-1:0] r_mag;
    logic [LEN_W-1:0]  r_rem;
    logic [LEN_W-1:0]  r_len;
    logic              r_neg;
    logic              r_done;
    logic [CHAN_W-1:0] r_step;

    logic [CHAN_W:0]     w_diff;
    logic [LEN_W:0]      w_rem_sh;
    logic                w_qbit;
    logic [LEN_W:0]      w_rem_new;
    logic [CHAN_W-1:0]   w_quo;
    logic [CHAN_W+LEN_W-1:0] w_prod;

    // Signed channel difference and its magnitude at the start.
    assign w_diff = {1'b0, i_target} - {1'b0, i_base};

    // One restoring divide step per cycle.
    assign w_rem_sh  = {r_rem, r_mag[CHAN_W-1]};
    assign w_qbit    = (w_rem_sh >= {1'b0, r_len});
    assign w_rem_new = w_qbit ? (w_rem_sh - {1'b0, r_len}) : w_rem_sh;
    assign w_quo     = {r_mag[CHAN_W-2:0], w_qbit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_cnt  <= '0;
                r_base <= i_base;
                r_len  <= i_len;
                r_neg  <= w_diff[CHAN_W];
                r_mag  <= w_diff[CHAN_W] ? CHAN_W'(-w_diff) : w_diff[CHAN_W-1:0];
                r_rem  <= '0;
            end else if (r_busy) begin
                r_mag <= w_quo;
                r_rem <= w_rem_new[LEN_W-1:0];
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(CHAN_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                    // A zero ramp length has a zero step.
                    if (r_len == '0) begin
                        r_step <= '0;
                    end else begin
                        r_step <= r_neg ? (~w_quo + 1'b1) : w_quo;
                    end
                end else begin
                    r_done <= 1'b0;
                end
            end else begin
                r_done <= 1'b0;
            end
        end
    end

    // Entry value base + step * index, wrapped to the channel width.
    assign w_prod  = {{LEN_W{1'b0}}, r_step} * {{CHAN_W{1'b0}}, i_idx};
    assign o_color = r_base + w_prod[CHAN_W-1:0];
    assign o_done  = r_done;

endmodule

`default_nettype wire

[hdl/color_gradient_generator_core.sv]
//------------------------------------------------------------------------------
// color_gradient_generator_core
// Linear RGB gradient generator with mirror and offset modes.
//------------------------------------------------------------------------------
// A request is taken only while the block is idle. Taking it loads the three
// channel lanes, whose serial step dividers then run side by side, and the block
// then emits its entries one per cycle from the output register as long as the
// receiver does not stall. A plain request with zero count is taken but starts
// no lanes and emits no entries; a mirrored one with zero count emits one.
`timescale 1ns / 1ps
`default_nettype none

module color_gradient_generator_core
    import cgg_pkg::*;
#(
    parameter int unsigned MAX_COLORS = 64
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_item,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_item
);

    localparam int unsigned LEN_W = $clog2(MAX_COLORS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] r_total;
    logic [LEN_W-1:0] r_k;
    logic             r_out_valid;
    t_out_item        r_out;

    logic             w_accept;
    logic [LEN_W-1:0] w_count;
    logic [LEN_W-1:0] w_len;
    logic [LEN_W-1:0] w_total;
    logic [7:0]       w_tgt_r;
    logic [7:0]       w_tgt_g;
    logic [7:0]       w_tgt_b;
    logic             w_start;
    logic [LEN_W:0]   w_idx_full;
    logic [LEN_W-1:0] w_idx;
    logic [2:0]       w_done;
    logic [7:0]       w_red;
    logic [7:0]       w_green;
    logic [7:0]       w_blue;
    logic             w_load;
    logic             w_last;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && (r_state == S_IDLE);

    // Clamp the count, halve it for a mirrored run, and size the run.
    always_comb begin
        if (i_in_item.color_count > 7'(MAX_COLORS)) begin
            w_count = LEN_W'(MAX_COLORS);
        end else begin
            w_count = i_in_item.color_count[LEN_W-1:0];
        end
        w_len = i_in_item.mirror ? (w_count >> 1) : w_count;
        if (!i_in_item.mirror) begin
            w_total = w_len;
        end else if (w_len == '0) begin
            w_total = LEN_W'(1);
        end else begin
            w_total = w_len << 1;
        end
    end

    // Target colors, taken from the base in offset mode.
    assign w_tgt_r = i_in_item.use_offset ? (i_in_item.base_red - i_in_item.offset)
                                          : i_in_item.target_red;
    assign w_tgt_g = i_in_item.use_offset ? (i_in_item.base_green - i_in_item.offset)
                                          : i_in_item.target_green;
    assign w_tgt_b = i_in_item.use_offset ? (i_in_item.base_blue - i_in_item.offset)
                                          : i_in_item.target_blue;

    assign w_start = w_accept && (w_total != '0);

    // Ramp index: up to the length, then back down.
    assign w_idx_full = (r_k <= r_len) ? {1'b0, r_k}
                                       : (({1'b0, r_len} << 1) - {1'b0, r_k});
    assign w_idx      = w_idx_full[LEN_W-1:0];

    // Channel lanes.
    cgg_lane #(.LEN_W(LEN_W)) u_lane_red (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_base   (i_in_item.base_red),
        .i_target (w_tgt_r),
        .i_len    (w_len),
        .i_idx    (w_idx),
        .o_done   (w_done[0]),
        .o_color  (w_red)
    );

    cgg_lane #(.LEN_W(LEN_W)) u_lane_green (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_base   (i_in_item.base_green),
        .i_target (w_tgt_g),
        .i_len    (w_len),
        .i_idx    (w_idx),
        .o_done   (w_done[1]),
        .o_color  (w_green)
    );

    cgg_lane #(.LEN_W(LEN_W)) u_lane_blue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_start),
        .i_base   (i_in_item.base_blue),
        .i_target (w_tgt_b),
        .i_len    (w_len),
        .i_idx    (w_idx),
        .o_done   (w_done[2]),
        .o_color  (w_blue)
    );

    // The output register takes a new entry when it is empty or being drained.
    assign w_load = (r_state == S_EMIT) && (!r_out_valid || !i_out_stall);
    assign w_last = (r_k == r_total - 1'b1);

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && !w_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_len   <= w_len;
                        r_total <= w_total;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (&w_done) begin
                        r_k     <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (w_load) begin
                        r_out_valid    <= 1'b1;
                        r_out.red      <= w_red;
                        r_out.green    <= w_green;
                        r_out.blue     <= w_blue;
                        r_out.position <= 6'(r_k);
                        r_out.last     <= w_last;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

`default_nettype wire
